/* hdl/dpi_pkg.sv */
// ----------------------------------------------------------------------------
// dpi_pkg: shared types and constants for the A64 data-processing execute unit
// Instruction field codes, register file sizing and the structs that pass
// between the register file, the ALU and the top level.
// ----------------------------------------------------------------------------
package dpi_pkg;

	// register file sizing
	localparam int GeneralRegisters = 31;
	localparam int RegAddrW         = $clog2(GeneralRegisters + 1);
	localparam logic [RegAddrW-1:0] ZeroReg = RegAddrW'(GeneralRegisters);

	// opi codes (instruction bits 25:23)
	localparam logic [2:0] OPI_ADDSUB = 3'b010;
	localparam logic [2:0] OPI_MOVEW  = 3'b101;

	// move wide opc codes (instruction bits 30:29)
	localparam logic [1:0] OPC_MOVN = 2'b00;
	localparam logic [1:0] OPC_MOVZ = 2'b10;
	localparam logic [1:0] OPC_MOVK = 2'b11;

	// flag vector layout: N bit 3, Z bit 2, C bit 1, V bit 0
	localparam int FlagN = 3;
	localparam int FlagZ = 2;
	localparam int FlagC = 1;
	localparam int FlagV = 0;

	// register file write port
	typedef struct packed {
		logic                en;
		logic [RegAddrW-1:0] addr;
		logic [63:0]         data;
	} rf_wr_t;

	// execute result
	typedef struct packed {
		logic                recognized;
		logic                write_enable;
		logic [RegAddrW-1:0] dest_reg;
		logic [63:0]         write_value;
		logic                flags_we;
		logic [3:0]          flags;
	} exe_res_t;

endpackage

/* hdl/dpi_regfile.sv */
// ----------------------------------------------------------------------------
// dpi_regfile: general register file with two registered read ports
// One write port, two read ports whose data is registered at the read edge.
// Per-entry valid bits give the all-zero reset; register 31 reads as zero.
// A write in the same cycle as a read of that entry is bypassed.
// ----------------------------------------------------------------------------
module dpi_regfile (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [dpi_pkg::RegAddrW-1:0] raddr_a,
	input  logic [dpi_pkg::RegAddrW-1:0] raddr_b,
	input  dpi_pkg::rf_wr_t              wr,
	output logic [63:0]                  rdata_a,
	output logic [63:0]                  rdata_b
);

	typedef enum logic [1:0] {
		SEL_ZERO,
		SEL_MEM,
		SEL_BYP
	} rd_sel_t;

	logic [63:0] mem [dpi_pkg::GeneralRegisters];
	logic [dpi_pkg::GeneralRegisters-1:0] valid_q;
	logic [63:0] raw_a_q;
	logic [63:0] raw_b_q;
	logic [63:0] byp_q;
	rd_sel_t     sel_a_q;
	rd_sel_t     sel_b_q;
	rd_sel_t     sel_a_d;
	rd_sel_t     sel_b_d;

	// read source for each port, decided at the read edge
	always_comb begin
		if (wr.en && wr.addr == raddr_a) begin
			sel_a_d = SEL_BYP;
		end else if (raddr_a != dpi_pkg::ZeroReg && valid_q[raddr_a]) begin
			sel_a_d = SEL_MEM;
		end else begin
			sel_a_d = SEL_ZERO;
		end
		if (wr.en && wr.addr == raddr_b) begin
			sel_b_d = SEL_BYP;
		end else if (raddr_b != dpi_pkg::ZeroReg && valid_q[raddr_b]) begin
			sel_b_d = SEL_MEM;
		end else begin
			sel_b_d = SEL_ZERO;
		end
	end

	// storage array and registered reads
	always_ff @(posedge clk) begin
		if (wr.en && wr.addr != dpi_pkg::ZeroReg) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en && raddr_a != dpi_pkg::ZeroReg) begin
			raw_a_q <= mem[raddr_a];
		end
		if (rd_en && raddr_b != dpi_pkg::ZeroReg) begin
			raw_b_q <= mem[raddr_b];
		end
		if (wr.en) begin
			byp_q <= wr.data;
		end
	end

	// valid bits and read selects
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			sel_a_q <= SEL_ZERO;
			sel_b_q <= SEL_ZERO;
		end else begin
			if (wr.en && wr.addr != dpi_pkg::ZeroReg) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				sel_a_q <= sel_a_d;
				sel_b_q <= sel_b_d;
			end
		end
	end

	// resolve read data
	always_comb begin
		unique case (sel_a_q)
			SEL_MEM: rdata_a = raw_a_q;
			SEL_BYP: rdata_a = byp_q;
			default: rdata_a = '0;
		endcase
		unique case (sel_b_q)
			SEL_MEM: rdata_b = raw_b_q;
			SEL_BYP: rdata_b = byp_q;
			default: rdata_b = '0;
		endcase
	end

endmodule

/* hdl/dpi_alu.sv */
// ----------------------------------------------------------------------------
// dpi_alu: add/subtract immediate and move wide datapath
// Combinational execute of one instruction from its operands and the
// current NZCV flags.
// ----------------------------------------------------------------------------
module dpi_alu (
	input  logic [31:0]        instruction,
	input  logic [63:0]        op_n,
	input  logic [63:0]        op_d,
	input  logic [3:0]         flags,
	output dpi_pkg::exe_res_t  res
);

	logic        sf;
	logic [1:0]  opc;
	logic [2:0]  opi;
	logic [63:0] imm;
	logic [63:0] opb;
	logic        cin;
	logic [64:0] sum64;
	logic [32:0] sum32;
	logic [63:0] arith_r;
	logic        c_f;
	logic        v_f;
	logic        n_f;
	logic [5:0]  mv_sh;
	logic [63:0] field;
	logic [63:0] keep;
	logic [63:0] mv_val;
	logic        mv_has;
	logic        has_value;
	logic [63:0] value;

	assign sf  = instruction[31];
	assign opc = instruction[30:29];
	assign opi = instruction[25:23];

	// add/subtract: a 65-bit add, with 32-bit flags from a separate 33-bit low-half add
	always_comb begin
		imm   = instruction[22] ? {40'd0, instruction[21:10], 12'd0}
		                        : {52'd0, instruction[21:10]};
		cin   = opc[1];
		opb   = opc[1] ? ~imm : imm;
		sum64 = {1'b0, op_n} + {1'b0, opb} + 65'(cin);
		sum32 = {1'b0, op_n[31:0]} + {1'b0, opb[31:0]} + 33'(cin);
		if (sf) begin
			arith_r = sum64[63:0];
			c_f     = sum64[64];
			n_f     = sum64[63];
			v_f     = (op_n[63] == opb[63]) && (op_n[63] != sum64[63]);
		end else begin
			arith_r = {32'd0, sum32[31:0]};
			c_f     = sum32[32];
			n_f     = sum32[31];
			v_f     = (op_n[31] == opb[31]) && (op_n[31] != sum32[31]);
		end
	end

	// move wide: 16-bit field at hw*16
	always_comb begin
		mv_sh = {instruction[22:21], 4'd0};
		field = {48'd0, instruction[20:5]} << mv_sh;
		keep  = ~({48'd0, 16'hFFFF} << mv_sh);
		case (opc)
			dpi_pkg::OPC_MOVN: begin
				mv_val = ~field;
				mv_has = 1'b1;
			end
			dpi_pkg::OPC_MOVZ: begin
				mv_val = field;
				mv_has = 1'b1;
			end
			dpi_pkg::OPC_MOVK: begin
				mv_val = (op_d & keep) | field;
				mv_has = 1'b1;
			end
			default: begin
				mv_val = '0;
				mv_has = 1'b0;
			end
		endcase
		if (!sf) begin
			mv_val[63:32] = '0;
		end
	end

	// result selection
	always_comb begin
		res = '0;
		res.dest_reg = instruction[4:0];
		res.flags    = flags;
		has_value    = 1'b0;
		value        = '0;
		unique case (opi)
			dpi_pkg::OPI_ADDSUB: begin
				res.recognized = 1'b1;
				has_value      = 1'b1;
				value          = arith_r;
				if (opc[0]) begin
					res.flags_we           = 1'b1;
					res.flags[dpi_pkg::FlagN] = n_f;
					res.flags[dpi_pkg::FlagZ] = (arith_r == '0);
					res.flags[dpi_pkg::FlagC] = c_f;
					res.flags[dpi_pkg::FlagV] = v_f;
				end
			end
			dpi_pkg::OPI_MOVEW: begin
				res.recognized = 1'b1;
				has_value      = mv_has;
				value          = mv_val;
			end
			default: begin
				res.recognized = 1'b0;
			end
		endcase
		res.write_enable = has_value && (instruction[4:0] != dpi_pkg::ZeroReg);
		res.write_value  = res.write_enable ? value : '0;
	end

endmodule

/* hdl/arm64_dp_immediate_execute_unit.sv */
// ----------------------------------------------------------------------------
// arm64_dp_immediate_execute_unit: A64 add/sub immediate and move wide execute
// Keeps 31 general registers and NZCV, executes one instruction per
// transaction and returns the written value and the flags.
//
//  channel   dir  width  fields (low bit first)
//  s_axis    in   32     instruction
//  m_axis    out  80     recognized, write_enable, dest_reg[5], write_value[64],
//                        flag_n, flag_z, flag_c, flag_v, 5 zero pad bits
//
// One instruction per cycle sustained while the output is not stalled; each
// passes the operand read register, then executes into the result register.
// The register file and flags update at the edge the result is registered,
// so each instruction sees the state left by the one before it.
// Reset clears all registers through per-entry valid bits and the flags directly.
// A stalled output holds the result and the instruction behind it.
// ----------------------------------------------------------------------------
module arm64_dp_immediate_execute_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // instruction[31:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata    // recognized, write_enable, dest_reg,
	                                    // write_value, flag_n, flag_z, flag_c,
	                                    // flag_v, zero pad
);

	logic              s_accept;
	logic              exec;
	logic              valid_s1;
	logic [31:0]       instr_s1;
	logic              valid_s2;
	dpi_pkg::exe_res_t res_s2;
	dpi_pkg::exe_res_t res;
	dpi_pkg::rf_wr_t   rf_wr;
	logic [63:0]       op_n;
	logic [63:0]       op_d;
	logic [3:0]        flags_q;

	// handshake control
	assign exec          = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || exec;
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	// register file write from the executing instruction
	assign rf_wr.en   = exec && res.write_enable;
	assign rf_wr.addr = res.dest_reg;
	assign rf_wr.data = res.write_value;

	dpi_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (s_accept),
		.raddr_a (s_axis_tdata[9:5]),
		.raddr_b (s_axis_tdata[4:0]),
		.wr      (rf_wr),
		.rdata_a (op_n),
		.rdata_b (op_d)
	);

	dpi_alu u_alu (
		.instruction (instr_s1),
		.op_n        (op_n),
		.op_d        (op_d),
		.flags       (flags_q),
		.res         (res)
	);

	// stage 1 instruction register
	always_ff @(posedge clk) begin
		if (s_accept) begin
			instr_s1 <= s_axis_tdata;
		end
	end

	// stage 2 result register
	always_ff @(posedge clk) begin
		if (exec) begin
			res_s2 <= res;
		end
	end

	// valid bits and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			flags_q  <= '0;
		end else begin
			if (s_accept) begin
				valid_s1 <= 1'b1;
			end else if (exec) begin
				valid_s1 <= 1'b0;
			end
			if (exec) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
			if (exec && res.flags_we) begin
				flags_q <= res.flags;
			end
		end
	end

	// output packing
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {5'd0,
	                        res_s2.flags[dpi_pkg::FlagV],
	                        res_s2.flags[dpi_pkg::FlagC],
	                        res_s2.flags[dpi_pkg::FlagZ],
	                        res_s2.flags[dpi_pkg::FlagN],
	                        res_s2.write_value,
	                        res_s2.dest_reg,
	                        res_s2.write_enable,
	                        res_s2.recognized};

`ifndef SYNTHESIS
	a_exec_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		exec |=> m_axis_tvalid)
		else $error("executed instruction produced no result");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !exec |=> valid_s1 && $stable(instr_s1))
		else $error("stalled instruction lost");

	a_no_zr_write: assert property (@(posedge clk) disable iff (!arst_n)
		rf_wr.en |-> rf_wr.addr != dpi_pkg::ZeroReg)
		else $error("write to register 31");

	a_unrec_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !res_s2.recognized |-> !res_s2.write_enable)
		else $error("unrecognized instruction wrote a register");

	a_flags_only_exec: assert property (@(posedge clk) disable iff (!arst_n)
		!exec |=> $stable(flags_q))
		else $error("flags changed without an executing instruction");
`endif

endmodule

/* verif/arm64_dp_immediate_execute_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm64_dp_immediate_execute_checker: result predictor and scoreboard
// Watches both stream channels of the execute unit. Every accepted instruction
// is executed on a private copy of the register file and NZCV flags. The
// outcome is queued and then compared field by field with the next result
// transaction. Mismatches and the number of results still owed go to the
// testbench top.
// ----------------------------------------------------------------------------
module arm64_dp_immediate_execute_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // instruction[31:0]
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [79:0] m_axis_tdata,   // recognized, write_enable, dest_reg,
	                                    // write_value, flag_n, flag_z, flag_c,
	                                    // flag_v, zero pad
	output int          mismatches,
	output int          outstanding
);

	// one predicted result transaction
	typedef struct packed {
		logic                         recognized;
		logic                         write_enable;
		logic [dpi_pkg::RegAddrW-1:0] dest_reg;
		logic [63:0]                  write_value;
		logic [3:0]                   nzcv;
	} exec_result_t;

	logic [63:0]  gpr [dpi_pkg::GeneralRegisters];
	logic [3:0]   nzcv;
	exec_result_t predicted_results[$];

	// register 31 reads as zero
	function automatic logic [63:0] read_gpr(logic [dpi_pkg::RegAddrW-1:0] idx);
		return (idx == dpi_pkg::ZeroReg) ? 64'd0 : gpr[idx];
	endfunction

	// execute one instruction on the shadow state and return its result
	function automatic exec_result_t execute_instruction(logic [31:0] ins);
		exec_result_t res;
		logic         sf;
		logic [1:0]   opc;
		logic [63:0]  a;
		logic [63:0]  b;
		logic [63:0]  imm;
		logic [63:0]  r;
		logic [63:0]  field;
		logic [64:0]  sum64;
		logic [32:0]  sum32;
		logic [5:0]   sh;
		logic         c;
		logic         v;
		logic         n;
		logic         has_value;

		sf           = ins[31];
		opc          = ins[30:29];
		res          = '0;
		res.dest_reg = ins[4:0];
		has_value    = 1'b0;
		r            = '0;

		case (ins[25:23])
			dpi_pkg::OPI_ADDSUB: begin
				res.recognized = 1'b1;
				imm = {52'd0, ins[21:10]};
				if (ins[22]) begin
					imm = imm << 12;
				end
				a = read_gpr(ins[9:5]);
				// opc bit 1 selects subtract: a + ~imm + 1
				b = opc[1] ? ~imm : imm;
				if (sf) begin
					sum64 = {1'b0, a} + {1'b0, b} + 65'(opc[1]);
					r     = sum64[63:0];
					c     = sum64[64];
					v     = (a[63] == b[63]) && (r[63] != a[63]);
					n     = r[63];
				end else begin
					sum32 = {1'b0, a[31:0]} + {1'b0, b[31:0]} + 33'(opc[1]);
					r     = {32'd0, sum32[31:0]};
					c     = sum32[32];
					v     = (a[31] == b[31]) && (r[31] != a[31]);
					n     = r[31];
				end
				has_value = 1'b1;
				// opc bit 0 marks the flag-setting forms
				if (opc[0]) begin
					nzcv[dpi_pkg::FlagN] = n;
					nzcv[dpi_pkg::FlagZ] = (r == 64'd0);
					nzcv[dpi_pkg::FlagC] = c;
					nzcv[dpi_pkg::FlagV] = v;
				end
			end
			dpi_pkg::OPI_MOVEW: begin
				res.recognized = 1'b1;
				sh    = {ins[22:21], 4'd0};
				field = {48'd0, ins[20:5]} << sh;
				case (opc)
					dpi_pkg::OPC_MOVN: begin
						r         = ~field;
						has_value = 1'b1;
					end
					dpi_pkg::OPC_MOVZ: begin
						r         = field;
						has_value = 1'b1;
					end
					dpi_pkg::OPC_MOVK: begin
						r         = (read_gpr(ins[4:0]) & ~(64'hFFFF << sh)) | field;
						has_value = 1'b1;
					end
					default: begin
					end
				endcase
				// 32-bit form clears the upper half whatever hw says
				if (has_value && !sf) begin
					r[63:32] = '0;
				end
			end
			default: begin
			end
		endcase

		if (has_value && ins[4:0] != dpi_pkg::ZeroReg) begin
			gpr[ins[4:0]]    = r;
			res.write_enable = 1'b1;
			res.write_value  = r;
		end
		res.nzcv = nzcv;
		return res;
	endfunction

	task automatic check_field(string field_name, logic [63:0] expected,
	                           logic [63:0] actual);
		if (expected !== actual) begin
			mismatches++;
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
			         $time, field_name, expected, actual);
		end
	endtask

	// compare completed results first, then predict the new instruction
	always @(posedge clk or negedge arst_n) begin : monitor
		exec_result_t oldest;

		if (!arst_n) begin
			for (int i = 0; i < dpi_pkg::GeneralRegisters; i++) begin
				gpr[i] = '0;
			end
			nzcv = '0;
			predicted_results.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (predicted_results.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, expected none, actual 0x%0h",
					         $time, m_axis_tdata);
				end else begin
					oldest = predicted_results.pop_front();
					check_field("recognized", 64'(oldest.recognized),
					            64'(m_axis_tdata[0]));
					check_field("write_enable", 64'(oldest.write_enable),
					            64'(m_axis_tdata[1]));
					check_field("dest_reg", 64'(oldest.dest_reg),
					            64'(m_axis_tdata[6:2]));
					check_field("write_value", oldest.write_value, m_axis_tdata[70:7]);
					check_field("flag_n", 64'(oldest.nzcv[dpi_pkg::FlagN]),
					            64'(m_axis_tdata[71]));
					check_field("flag_z", 64'(oldest.nzcv[dpi_pkg::FlagZ]),
					            64'(m_axis_tdata[72]));
					check_field("flag_c", 64'(oldest.nzcv[dpi_pkg::FlagC]),
					            64'(m_axis_tdata[73]));
					check_field("flag_v", 64'(oldest.nzcv[dpi_pkg::FlagV]),
					            64'(m_axis_tdata[74]));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				predicted_results.push_back(execute_instruction(s_axis_tdata));
			end
			outstanding = predicted_results.size();
		end
	end

endmodule

/* verif/arm64_dp_immediate_execute_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm64_dp_immediate_execute_unit_tb: stimulus and verdict for the execute unit
// Sends a directed list of corner-case instructions (carry, borrow, overflow
// in both widths, register 31, the unallocated move wide opc, other opi
// codes), then about a thousand random instructions biased toward a few
// registers so that values chain through MOVK and the arithmetic forms.
// Both channels idle at random, and the output is held off once for a long
// stretch. The checker module does all predicting and comparing.
// ----------------------------------------------------------------------------
module arm64_dp_immediate_execute_unit_tb;

	// add/sub immediate opc codes
	localparam logic [1:0] OPC_ADD  = 2'b00;
	localparam logic [1:0] OPC_ADDS = 2'b01;
	localparam logic [1:0] OPC_SUB  = 2'b10;
	localparam logic [1:0] OPC_SUBS = 2'b11;
	// move wide opc with no operation assigned
	localparam logic [1:0] OPC_MOVW_NONE = 2'b01;
	// bits 28:26 of the data-processing immediate group
	localparam logic [2:0] DP_IMM_GROUP = 3'b100;

	localparam int RandomItems   = 1000;
	localparam int CycleLimit    = 500000;
	localparam int HoldOffAt     = 400;
	localparam int HoldOffCycles = 200;
	localparam int DrainCycles   = 10;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [79:0] m_axis_tdata;

	int mismatches;
	int outstanding;
	int accepted = 0;
	int cycles;
	bit holdoff_done = 1'b0;

	arm64_dp_immediate_execute_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	arm64_dp_immediate_execute_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// watchdog
	initial begin
		cycles = 0;
		while (cycles < CycleLimit) begin
			@(posedge clk);
			cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	function automatic logic [31:0] enc_addsub(logic sf, logic [1:0] opc, logic sh,
	                                           logic [11:0] imm12, logic [4:0] rn,
	                                           logic [4:0] rd);
		return {sf, opc, DP_IMM_GROUP, dpi_pkg::OPI_ADDSUB, sh, imm12, rn, rd};
	endfunction

	function automatic logic [31:0] enc_movew(logic sf, logic [1:0] opc, logic [1:0] hw,
	                                          logic [15:0] imm16, logic [4:0] rd);
		return {sf, opc, DP_IMM_GROUP, dpi_pkg::OPI_MOVEW, hw, imm16, rd};
	endfunction

	// mostly a small register set so results feed later instructions
	function automatic logic [4:0] pick_reg();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return 5'($urandom_range(0, 7));
		end else if (r < 80) begin
			return dpi_pkg::ZeroReg;
		end
		return 5'($urandom_range(0, 31));
	endfunction

	function automatic logic [31:0] random_instruction();
		int          r;
		int          k;
		logic [31:0] ins;
		logic [11:0] imm12;
		logic [15:0] imm16;

		r = $urandom_range(0, 99);
		k = $urandom_range(0, 3);
		if (r < 45) begin
			imm12 = (k == 0) ? 12'h000 : (k == 1) ? 12'hFFF : 12'($urandom);
			ins = enc_addsub(1'($urandom), 2'($urandom), 1'($urandom), imm12,
			                 pick_reg(), pick_reg());
			ins[28:26] = 3'($urandom);
		end else if (r < 85) begin
			imm16 = (k == 0) ? 16'h0000 : (k == 1) ? 16'hFFFF : 16'($urandom);
			ins = enc_movew(1'($urandom), 2'($urandom), 2'($urandom), imm16, pick_reg());
			ins[28:26] = 3'($urandom);
		end else begin
			ins = $urandom();
		end
		return ins;
	endfunction

	// mostly back to back, sometimes short gaps, rarely long ones
	function automatic int pick_gap(bit busy);
		int r;
		r = $urandom_range(0, 99);
		if (busy || r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else if (r < 98) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	task automatic send_instruction(input logic [31:0] ins, input int gap);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= ins;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		accepted++;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// output side: random stalls, one long hold-off to back up the pipe
	initial begin : sink
		int r;
		bit busy;

		while (!arst_n) begin
			@(posedge clk);
		end
		forever begin
			r    = $urandom_range(0, 99);
			busy = ((accepted / 100) % 3) == 1;
			if (!holdoff_done && accepted >= HoldOffAt) begin
				holdoff_done = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HoldOffCycles) @(posedge clk);
			end else if (busy || r < 70) begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else if (r < 95) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(10, 40)) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		logic [31:0] directed[$];

		while (!arst_n) begin
			@(posedge clk);
		end
		@(posedge clk);

		// 64-bit carry, borrow and overflow around all-ones and max positive
		directed.push_back(enc_movew(1'b1, dpi_pkg::OPC_MOVZ, 2'd3, 16'hFFFF, 5'd0));
		directed.push_back(enc_movew(1'b1, dpi_pkg::OPC_MOVN, 2'd0, 16'h0000, 5'd1));
		directed.push_back(enc_addsub(1'b1, OPC_ADDS, 1'b0, 12'd1, 5'd1, 5'd2));
		directed.push_back(enc_addsub(1'b1, OPC_SUBS, 1'b0, 12'd1, dpi_pkg::ZeroReg, 5'd3));
		directed.push_back(enc_addsub(1'b1, OPC_ADD, 1'b1, 12'hFFF, 5'd1, 5'd4));
		directed.push_back(enc_movew(1'b1, dpi_pkg::OPC_MOVN, 2'd3, 16'h8000, 5'd5));
		directed.push_back(enc_addsub(1'b1, OPC_ADDS, 1'b0, 12'd1, 5'd5, 5'd6));
		// 32-bit overflow: build 0x7fffffff, then add one
		directed.push_back(enc_movew(1'b0, dpi_pkg::OPC_MOVZ, 2'd1, 16'h7FFF, 5'd7));
		directed.push_back(enc_movew(1'b0, dpi_pkg::OPC_MOVK, 2'd0, 16'hFFFF, 5'd7));
		directed.push_back(enc_addsub(1'b0, OPC_ADDS, 1'b0, 12'd1, 5'd7, 5'd8));
		// equal operands, max immediate, 32-bit carry out
		directed.push_back(enc_addsub(1'b0, OPC_SUBS, 1'b0, 12'd0, dpi_pkg::ZeroReg, 5'd9));
		directed.push_back(enc_addsub(1'b1, OPC_SUBS, 1'b0, 12'hFFF, 5'd0, 5'd10));
		directed.push_back(enc_addsub(1'b0, OPC_ADDS, 1'b1, 12'hFFF, 5'd1, 5'd11));
		// register 31 as destination: flags still set, no write
		directed.push_back(enc_addsub(1'b1, OPC_SUBS, 1'b0, 12'd1, 5'd1, dpi_pkg::ZeroReg));
		directed.push_back(enc_movew(1'b1, dpi_pkg::OPC_MOVZ, 2'd0, 16'h1234,
		                             dpi_pkg::ZeroReg));
		// move wide with no operation, 32-bit forms with high hw
		directed.push_back(enc_movew(1'b1, OPC_MOVW_NONE, 2'd2, 16'hFFFF, 5'd12));
		directed.push_back(enc_movew(1'b0, dpi_pkg::OPC_MOVN, 2'd3, 16'h1234, 5'd13));
		directed.push_back(enc_movew(1'b0, dpi_pkg::OPC_MOVK, 2'd2, 16'hABCD, 5'd1));
		directed.push_back(enc_movew(1'b1, dpi_pkg::OPC_MOVK, 2'd1, 16'h5555, 5'd0));
		// other opi codes
		directed.push_back(32'hFFFF_FFFF);
		directed.push_back(32'h0000_0000);
		// non-flag forms leave NZCV alone
		directed.push_back(enc_addsub(1'b1, OPC_ADD, 1'b0, 12'd1, 5'd0, 5'd14));
		directed.push_back(enc_addsub(1'b0, OPC_SUB, 1'b1, 12'd1, 5'd0, 5'd15));

		foreach (directed[i]) begin
			send_instruction(directed[i], pick_gap(1'b0));
		end
		for (int i = 0; i < RandomItems; i++) begin
			send_instruction(random_instruction(), pick_gap(((i / 100) % 3) == 1));
		end
		s_axis_tvalid <= 1'b0;

		// sample the owed count away from the clock edge
		do begin
			@(negedge clk);
		end while (outstanding != 0);
		repeat (DrainCycles) @(posedge clk);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
